FILE: hw/rtl/prg_pkg.sv
`timescale 1ns / 1ps

package prg_pkg;

  // Command codes carried by an input transaction
  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_CHECK = 3'd1,
    FUNC_START = 3'd2,
    FUNC_STOP  = 3'd3,
    FUNC_PULSE = 3'd4,
    FUNC_CLEAR = 3'd5
  } func_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_CAPACITY      = 1'b0,
    CFG_DEFAULT_PULSE = 1'b1
  } cfg_idx_t;

  localparam int unsigned MS_W   = 32;
  localparam int unsigned SEC_W  = 23;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned FUNC_W = 3;

  localparam logic [MS_W-1:0] CAPACITY_RESET      = 32'd60000;
  localparam logic [MS_W-1:0] DEFAULT_PULSE_RESET = 32'd1000;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam int unsigned     RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h10624DD3;
  localparam int unsigned     RECIP_SHIFT = 38;
  localparam int unsigned     PROD_W      = MS_W + RECIP_W;

  // Flags and counter that travel with the times down the pipeline
  typedef struct packed {
    logic             pump_drive;
    logic             timeout_flag;
    logic             pulse_active;
    logic [CNT_W-1:0] start_count;
  } status_t;

endpackage

FILE: hw/rtl/pump_runtime_guard_core.sv
`timescale 1ns / 1ps

// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// item     | item_valid / item_stall   | func, pulse_ms
// result   | result_valid/result_stall | pump_drive, timeout_flag, pulse_active,
//          |                           | start_count, run_time_sec, elapsed_sec,
//          |                           | since_stop_sec
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; a result passes three
// registers after its item is taken (state update, divide-by-1000 multiply, output register).
// The guard state updates in the cycle an item is accepted, so items follow back
// to back. Each stage holds only while it is full and the stage after it stalls;
// item_stall rises only when all three stages are full and the result stalls.
// rst is synchronous: state clears, registers load their reset values.
module pump_runtime_guard_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [prg_pkg::FUNC_W-1:0]    func,
  input  logic [prg_pkg::MS_W-1:0]      pulse_ms,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          pump_drive,
  output logic                          timeout_flag,
  output logic                          pulse_active,
  output logic [prg_pkg::CNT_W-1:0]     start_count,
  output logic [prg_pkg::SEC_W-1:0]     run_time_sec,
  output logic [prg_pkg::SEC_W-1:0]     elapsed_sec,
  output logic [prg_pkg::SEC_W-1:0]     since_stop_sec,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [prg_pkg::MS_W-1:0]      cfg_data
);
  import prg_pkg::*;

  // Configuration
  logic [MS_W-1:0] capacity_ms;
  logic [MS_W-1:0] default_pulse_ms;

  // Guard state; the three times are kept as running differences
  logic [MS_W-1:0]  run_ms,        run_ms_next;
  logic [MS_W-1:0]  elapsed_ms,    elapsed_ms_next;
  logic [MS_W-1:0]  since_stop_ms, since_stop_ms_next;
  logic [MS_W-1:0]  run_total,     run_total_next;
  logic [CNT_W-1:0] starts,        starts_next;
  logic             running,       running_next;
  logic             timed_out,     timed_out_next;
  logic [MS_W-1:0]  pulse_left,    pulse_left_next;

  // Pipeline
  logic                v1, v2, v3;
  logic                ready1, ready2, ready3;
  status_t             st1, st2, st3;
  logic [MS_W-1:0]     total1, elapsed1, since1;
  logic [PROD_W-1:0]   total_prod, elapsed_prod, since_prod;

  logic            accept;
  func_t           func_code;
  logic [MS_W-1:0] run_add;
  logic [MS_W-1:0] sum_ms;
  logic            hit;
  logic [MS_W-1:0] len;
  logic            off_req;

  assign func_code = func_t'(func);
  assign accept    = item_valid && !item_stall;
  assign cfg_ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_ms      <= CAPACITY_RESET;
      default_pulse_ms <= DEFAULT_PULSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAPACITY:      capacity_ms      <= cfg_data;
        CFG_DEFAULT_PULSE: default_pulse_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run total plus current run; a tick adds its millisecond through the carry
  assign run_add = running ? run_ms : '0;
  assign sum_ms  = run_total + run_add + {{(MS_W-1){1'b0}}, (func_code == FUNC_TICK)};
  assign hit     = (sum_ms >= capacity_ms);
  assign len     = (pulse_ms == '0) ? default_pulse_ms : pulse_ms;

  // Next guard state for the command at the input
  always_comb begin
    run_ms_next        = run_ms;
    elapsed_ms_next    = elapsed_ms;
    since_stop_ms_next = since_stop_ms;
    run_total_next     = run_total;
    starts_next        = starts;
    running_next       = running;
    timed_out_next     = timed_out;
    pulse_left_next    = pulse_left;
    off_req            = 1'b0;
    unique case (func_code)
      FUNC_TICK: begin
        run_ms_next        = run_ms + 1'b1;
        elapsed_ms_next    = elapsed_ms + 1'b1;
        since_stop_ms_next = since_stop_ms + 1'b1;
        if (pulse_left != '0) begin
          pulse_left_next = pulse_left - 1'b1;
          off_req         = (pulse_left == {{(MS_W-1){1'b0}}, 1'b1}) && running;
        end
      end
      FUNC_CHECK: begin
        off_req = running && !timed_out && hit;
      end
      FUNC_START: begin
        if (!running && !timed_out) begin
          running_next = 1'b1;
          starts_next  = starts + 1'b1;
          run_ms_next  = '0;
        end
      end
      FUNC_STOP: begin
        off_req         = running;
        pulse_left_next = '0;
      end
      FUNC_PULSE: begin
        if (!timed_out) begin
          if (!running) begin
            running_next = 1'b1;
            starts_next  = starts + 1'b1;
            run_ms_next  = '0;
          end
          pulse_left_next = len;
          off_req         = (len == '0);
        end
      end
      FUNC_CLEAR: begin
        run_ms_next        = '0;
        elapsed_ms_next    = '0;
        since_stop_ms_next = '0;
        run_total_next     = '0;
        starts_next        = '0;
        running_next       = 1'b0;
        timed_out_next     = 1'b0;
      end
      default: ;
    endcase
    // Stop the pump and book the run
    if (off_req) begin
      running_next       = 1'b0;
      since_stop_ms_next = '0;
      run_total_next     = sum_ms;
      timed_out_next     = hit;
    end
  end

  // Update guard state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      run_ms        <= '0;
      elapsed_ms    <= '0;
      since_stop_ms <= '0;
      run_total     <= '0;
      starts        <= '0;
      running       <= 1'b0;
      timed_out     <= 1'b0;
      pulse_left    <= '0;
    end else if (accept) begin
      run_ms        <= run_ms_next;
      elapsed_ms    <= elapsed_ms_next;
      since_stop_ms <= since_stop_ms_next;
      run_total     <= run_total_next;
      starts        <= starts_next;
      running       <= running_next;
      timed_out     <= timed_out_next;
      pulse_left    <= pulse_left_next;
    end
  end

  // Advance a stage when it is empty or its successor takes its contents
  assign ready3     = !v3 || !result_stall;
  assign ready2     = !v2 || ready3;
  assign ready1     = !v1 || ready2;
  assign item_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= accept;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // Stage 1: snapshot of the state after the command
  always_ff @(posedge clk) begin
    if (ready1 && accept) begin
      st1.pump_drive   <= running_next;
      st1.timeout_flag <= timed_out_next;
      st1.pulse_active <= (pulse_left_next != '0);
      st1.start_count  <= starts_next;
      total1           <= run_total_next;
      elapsed1         <= elapsed_ms_next;
      since1           <= since_stop_ms_next;
    end
  end

  // Stage 2: multiply by the reciprocal of 1000
  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      st2          <= st1;
      total_prod   <= PROD_W'(total1) * PROD_W'(RECIP_1000);
      elapsed_prod <= PROD_W'(elapsed1) * PROD_W'(RECIP_1000);
      since_prod   <= PROD_W'(since1) * PROD_W'(RECIP_1000);
    end
  end

  // Stage 3: result register holds while stalled
  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      st3            <= st2;
      run_time_sec   <= total_prod[PROD_W-1:RECIP_SHIFT];
      elapsed_sec    <= elapsed_prod[PROD_W-1:RECIP_SHIFT];
      since_stop_sec <= since_prod[PROD_W-1:RECIP_SHIFT];
    end
  end

  assign result_valid = v3;
  assign pump_drive   = st3.pump_drive;
  assign timeout_flag = st3.timeout_flag;
  assign pulse_active = st3.pulse_active;
  assign start_count  = st3.start_count;

  // A running pump never coexists with a latched timeout
  a_run_not_timed: assert property (@(posedge clk) disable iff (rst)
    running |-> !timed_out)
    else $error("pump running while timed out");

  // Clear zeroes the statistics
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_CLEAR) |=> (run_total == '0) && (starts == '0) && !timed_out)
    else $error("clear left statistics");

  // A start while running does not count a run
  a_start_running: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_START) && running |=> (starts == $past(starts)))
    else $error("start counted while running");

  // Input holds off only with the whole pipeline full and the result stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> v1 && v2 && v3 && result_stall)
    else $error("input stalled with room in pipeline");

endmodule

FILE: sim/tb_pump_runtime_guard_core.sv
`timescale 1ns / 1ps

module tb_pump_runtime_guard_core;
  import prg_pkg::*;

  // Command codes the package leaves unnamed; the block must leave its state unchanged for them
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  localparam logic [MS_W-1:0] MS_PER_SEC  = 32'd1000;
  localparam logic [MS_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam int              DRAIN_LIMIT = 5000;
  localparam int              TAIL_CYCLES = 8;
  localparam int              PHASE_ITEMS = 90;

  typedef struct packed {
    logic             drive;
    logic             tmo;
    logic             pulse_on;
    logic [CNT_W-1:0] runs;
    logic [SEC_W-1:0] run_s;
    logic [SEC_W-1:0] elapsed_s;
    logic [SEC_W-1:0] since_stop_s;
  } guard_status_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  logic [FUNC_W-1:0] func         = FUNC_TICK;
  logic [MS_W-1:0]   pulse_ms     = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic              pump_drive;
  logic              timeout_flag;
  logic              pulse_active;
  logic [CNT_W-1:0]  start_count;
  logic [SEC_W-1:0]  run_time_sec;
  logic [SEC_W-1:0]  elapsed_sec;
  logic [SEC_W-1:0]  since_stop_sec;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic              cfg_index    = 1'b0;
  logic [MS_W-1:0]   cfg_data     = '0;

  pump_runtime_guard_core dut (.*);

  always #1 clk = ~clk;

  // Guard state mirrored by the predictor
  logic [MS_W-1:0]  cap_ms       = CAPACITY_RESET;
  logic [MS_W-1:0]  dflt_pulse   = DEFAULT_PULSE_RESET;
  logic [MS_W-1:0]  clock_ms     = '0;
  logic [MS_W-1:0]  run_begin_ms = '0;
  logic [MS_W-1:0]  last_stop_ms = '0;
  logic [MS_W-1:0]  epoch_ms     = '0;
  logic [MS_W-1:0]  total_run_ms = '0;
  logic [MS_W-1:0]  pulse_left   = '0;
  logic [CNT_W-1:0] start_tally  = '0;
  logic             pump_on      = 1'b0;
  logic             latched_out  = 1'b0;

  guard_status_t status_q[$];
  guard_status_t oldest;

  bit idle_in  = 1'b1;
  bit idle_out = 1'b1;
  int stall_left;
  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int timeout_latches = 0;
  int pulse_expiries  = 0;
  int check_cutoffs   = 0;

  // Turn the pump on unless it already runs or the timeout holds it off
  function automatic void pump_engage();
    if (!pump_on && !latched_out) begin
      pump_on      = 1'b1;
      start_tally  = start_tally + 1'b1;
      run_begin_ms = clock_ms;
    end
  endfunction

  // Turn the pump off, book the run length and re-evaluate the timeout
  function automatic void pump_cutoff();
    if (pump_on) begin
      last_stop_ms = clock_ms;
      total_run_ms = total_run_ms + (last_stop_ms - run_begin_ms);
      latched_out  = (total_run_ms >= cap_ms);
      if (latched_out) timeout_latches++;
      pump_on = 1'b0;
    end
  endfunction

  // Apply one command to the mirrored state and return the status it leaves
  function automatic guard_status_t step_guard(logic [FUNC_W-1:0] f, logic [MS_W-1:0] req);
    logic [MS_W-1:0] len;
    logic [MS_W-1:0] projected;
    guard_status_t   st;
    case (f)
      FUNC_TICK: begin
        clock_ms = clock_ms + 1'b1;
        if (pulse_left != 0) begin
          pulse_left = pulse_left - 1'b1;
          if (pulse_left == 0) begin
            pump_cutoff();
            pulse_expiries++;
          end
        end
      end
      FUNC_CHECK: begin
        projected = clock_ms - run_begin_ms + total_run_ms;
        if (pump_on && !latched_out && projected >= cap_ms) begin
          pump_cutoff();
          check_cutoffs++;
        end
      end
      FUNC_START: pump_engage();
      FUNC_STOP: begin
        pump_cutoff();
        pulse_left = '0;
      end
      FUNC_PULSE: begin
        if (!latched_out) begin
          len = (req == 0) ? dflt_pulse : req;
          pump_engage();
          if (len == 0) begin
            pump_cutoff();
            pulse_left = '0;
          end else begin
            pulse_left = len;
          end
        end
      end
      FUNC_CLEAR: begin
        pump_cutoff();
        run_begin_ms = clock_ms;
        last_stop_ms = clock_ms;
        epoch_ms     = clock_ms;
        start_tally  = '0;
        total_run_ms = '0;
        pump_on      = 1'b0;
        latched_out  = 1'b0;
      end
      default: ;
    endcase
    st.drive        = pump_on;
    st.tmo          = latched_out;
    st.pulse_on     = (pulse_left != 0);
    st.runs         = start_tally;
    st.run_s        = SEC_W'(total_run_ms / MS_PER_SEC);
    st.elapsed_s    = SEC_W'(MS_W'(clock_ms - epoch_ms) / MS_PER_SEC);
    st.since_stop_s = SEC_W'(MS_W'(clock_ms - last_stop_ms) / MS_PER_SEC);
    return st;
  endfunction

  function automatic void compare_field(string name, logic [MS_W-1:0] want,
                                        logic [MS_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Stall the result channel at random after each transaction while idle_out is set
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else begin
      if (result_valid === 1'b1 && !result_stall)
        stall_left = idle_out ? $urandom_range(0, 15) : 0;
      else if (stall_left != 0)
        stall_left--;
      result_stall <= (stall_left != 0);
    end
  end

  // Compare every accepted result with the oldest pending status
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (status_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result transaction with no status pending", $time);
      end else begin
        oldest = status_q.pop_front();
        compare_field("pump_drive", MS_W'(oldest.drive), MS_W'(pump_drive));
        compare_field("timeout_flag", MS_W'(oldest.tmo), MS_W'(timeout_flag));
        compare_field("pulse_active", MS_W'(oldest.pulse_on), MS_W'(pulse_active));
        compare_field("start_count", MS_W'(oldest.runs), MS_W'(start_count));
        compare_field("run_time_sec", MS_W'(oldest.run_s), MS_W'(run_time_sec));
        compare_field("elapsed_sec", MS_W'(oldest.elapsed_s), MS_W'(elapsed_sec));
        compare_field("since_stop_sec", MS_W'(oldest.since_stop_s),
                      MS_W'(since_stop_sec));
        results_checked++;
      end
    end
  end

  // Offer one command, wait for the transaction and queue the predicted status
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [MS_W-1:0] req);
    int gap;
    gap = idle_in ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    func       <= f;
    pulse_ms   <= req;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    status_q.push_back(step_guard(f, req));
    items_sent++;
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_cmd(FUNC_TICK, $urandom);
  endtask

  // Drop valid and wait until every pending status has been matched
  task automatic drain();
    int waited;
    item_valid <= 1'b0;
    waited = 0;
    while (status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (status_q.size() != 0) begin
      mismatch_count++;
      $display("%0t ns: %0d expected results never arrived", $time, status_q.size());
      status_q.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic configure(input logic [MS_W-1:0] cap, input logic [MS_W-1:0] dflt);
    drain();
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_CAPACITY : CFG_DEFAULT_PULSE;
      cfg_data  <= (i == 0) ? cap : dflt;
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cap_ms     = cap;
    dflt_pulse = dflt;
    settings_used++;
  endtask

  // Walk every command under the reset register values
  task automatic test_command_set();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_CHECK, '0);
    send_cmd(FUNC_STOP, '0);
    send_cmd(FUNC_START, '0);
    send_cmd(FUNC_START, ALL_ONES);
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_CHECK, '0);
    // pulse on a running pump rearms with the default length
    send_cmd(FUNC_PULSE, '0);
    send_cmd(FUNC_STOP, '0);
    send_cmd(FUNC_SPARE6, ALL_ONES);
    send_cmd(FUNC_SPARE7, '0);
    // short pulse that expires through the ticks
    send_cmd(FUNC_PULSE, 32'd3);
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_CHECK, '0);
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_TICK, '0);
    // clear during a pulse keeps the countdown alive
    send_cmd(FUNC_PULSE, ALL_ONES);
    send_cmd(FUNC_CLEAR, '0);
    send_cmd(FUNC_START, '0);
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_STOP, '0);
    // countdown ends with the pump already off
    send_cmd(FUNC_PULSE, 32'd2);
    send_cmd(FUNC_CLEAR, '0);
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_TICK, '0);
  endtask

  // Reach capacity by check, then confirm starts and pulses are locked out
  task automatic test_timeout_latch();
    configure(32'd5, '0);
    send_cmd(FUNC_PULSE, '0);
    send_cmd(FUNC_START, '0);
    tick_run(3);
    send_cmd(FUNC_CHECK, '0);
    tick_run(2);
    send_cmd(FUNC_CHECK, '0);
    send_cmd(FUNC_START, '0);
    send_cmd(FUNC_PULSE, 32'd7);
    send_cmd(FUNC_STOP, '0);
    send_cmd(FUNC_CLEAR, '0);
  endtask

  // Run one full second so every seconds counter moves; the last check cuts the pump
  task automatic test_long_run();
    idle_in  = 1'b0;
    idle_out = 1'b1;
    configure(32'd1000, DEFAULT_PULSE_RESET);
    send_cmd(FUNC_CLEAR, '0);
    send_cmd(FUNC_START, '0);
    repeat (10) begin
      tick_run(100);
      send_cmd(FUNC_CHECK, $urandom);
    end
    send_cmd(FUNC_STOP, '0);
    send_cmd(FUNC_CLEAR, '0);
  endtask

  // Random command sequences under several register settings
  task automatic test_random_mix();
    int phase;
    int stop_at;
    int choice;
    int span;
    int pick;
    logic [MS_W-1:0] len;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: configure($urandom_range(10, 300), $urandom_range(1, 40));
        1: configure('0, '0);
        2: configure(ALL_ONES, ALL_ONES);
        3: configure($urandom, $urandom);
        default: configure($urandom_range(1, 60), '0);
      endcase
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 7) == 0) idle_in = !idle_in;
        if ($urandom_range(0, 7) == 0) idle_out = !idle_out;
        // release a latched timeout most of the time so runs keep happening
        if (latched_out && $urandom_range(0, 2) != 0) send_cmd(FUNC_CLEAR, $urandom);
        choice = $urandom_range(0, 99);
        if (choice < 35) begin
          // plain run with checks scattered among the ticks
          send_cmd(FUNC_START, $urandom);
          span = $urandom_range(0, 30);
          repeat (span) begin
            if ($urandom_range(0, 3) == 0) send_cmd(FUNC_CHECK, $urandom);
            else send_cmd(FUNC_TICK, $urandom);
          end
          pick = $urandom_range(0, 9);
          if (pick < 8) send_cmd(FUNC_STOP, $urandom);
          else if (pick == 8) send_cmd(FUNC_CLEAR, $urandom);
        end else if (choice < 65) begin
          // pulse followed by ticks with other commands mixed in
          pick = $urandom_range(0, 99);
          if (pick < 25) len = '0;
          else if (pick < 85) len = $urandom_range(1, 40);
          else len = $urandom;
          send_cmd(FUNC_PULSE, len);
          span = $urandom_range(0, 45);
          repeat (span) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) send_cmd(FUNC_CHECK, $urandom);
            else if (pick == 1) send_cmd(FUNC_START, $urandom);
            else if (pick == 2) send_cmd(FUNC_CLEAR, $urandom);
            else if (pick == 3) send_cmd(FUNC_PULSE, $urandom_range(0, 20));
            else if (pick == 4) send_cmd(FUNC_STOP, $urandom);
            else send_cmd(FUNC_TICK, $urandom);
          end
        end else if (choice < 80) begin
          // noise: any code including the unused ones
          repeat ($urandom_range(1, 6))
            send_cmd(FUNC_W'($urandom_range(0, 7)), $urandom);
        end else if (choice < 90) begin
          send_cmd(FUNC_CLEAR, $urandom);
        end else begin
          tick_run($urandom_range(1, 20));
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_command_set();
    test_timeout_latch();
    test_long_run();
    test_random_mix();
    drain();
    $display("Ran %0d commands under %0d register settings, %0d results compared.",
             items_sent, settings_used, results_checked);
    $display("Timeout latched %0d times, %0d pulses expired, check cut the pump %0d times.",
             timeout_latches, pulse_expiries, check_cutoffs);
    if (mismatch_count == 0) begin
      $display("** pump_runtime_guard_core: PASSED **");
    end else begin
      $display("** pump_runtime_guard_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: stop a hung run
  initial begin
    #2_000_000;
    $display("%0t ns: run did not complete in time", $time);
    $display("** pump_runtime_guard_core: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/prg_pkg.sv
hw/rtl/pump_runtime_guard_core.sv
sim/tb_pump_runtime_guard_core.sv
